>>> design/rhcc_pkg.sv
// ----------------------------------------------------------------------------
// rhcc_pkg: shared types and constants for the RGB / HSV color converter
// Item structs, fixed-point constants and pipeline geometry.
// ----------------------------------------------------------------------------
package rhcc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ONE_W      = FRAC_BITS + 1;
    localparam logic [ONE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // divisor of the hue division is 6*(max-min), at most 1530
    localparam int DIVISOR_W  = 11;
    // two quotient bits per divider stage
    localparam int DIV_STAGES = FRAC_BITS / 2;
    // stage 1 min/max, stage 2 setup, divider stages, output stage
    localparam int DEPTH      = DIV_STAGES + 3;

    // byte conversion: floor(x * 2559 / (10 * ONE))
    localparam logic [11:0] BYTE_SCALE = 12'd2559;
    // floor(u / 10) == (u * 6554) >> 16 for u <= 2559
    localparam logic [12:0] TENTH_MUL  = 13'd6554;

    typedef enum logic [1:0] {
        MAX_R = 2'd0,
        MAX_G = 2'd1,
        MAX_B = 2'd2
    } max_sel_t;

    typedef struct packed {
        logic        mode;
        logic [23:0] rgb_in;
        logic [15:0] hue_in;
        logic [16:0] whiteness_in;
        logic [16:0] brightness_in;
    } in_item_t;

    typedef struct packed {
        logic [23:0] rgb_out;
        logic [15:0] hue_out;
        logic [16:0] whiteness_out;
        logic [16:0] brightness_out;
    } out_item_t;

endpackage

>>> design/rgb_hsv_color_conversion.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_conversion: RGB <-> hue/whiteness/brightness converter
// Fully pipelined, one color per clock in either direction.
// ----------------------------------------------------------------------------
// One item may be issued on every clock: busy is tied low and the block never
// pushes back. Each item comes out as a one-cycle done strobe with the result;
// the receiver cannot stall it, so it must take every result in the cycle it
// appears. The pipeline depth is set by the two restoring dividers (whiteness =
// min/max and the hue quotient), which retire two quotient bits per stage. Mode 0
// echoes rgb_in, mode 1 echoes hue, whiteness and brightness. No state is kept
// between items.
// ----------------------------------------------------------------------------
module rgb_hsv_color_conversion
    import rhcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      done,
    output out_item_t result
);

    // pipeline control and echoed item
    logic [DEPTH:1] vld_reg;
    in_item_t       item_reg [1:DEPTH];

    // stage 1
    logic [7:0]            mx1_next, mn1_next, mx1_reg, mn1_reg;
    max_sel_t              msel1_next, msel1_reg;
    logic [FRAC_BITS+2:0]  t1_next;
    logic [2:0]            sext1_reg;
    logic [FRAC_BITS-1:0]  frac1_reg;

    // stage 2, rgb to hsv setup
    logic [7:0]            d2;
    logic [DIVISOR_W-1:0]  d6_2, n_red2, n2_next;
    logic [ONE_W-1:0]      w2_next;
    logic [ONE_W-1:0]      w2_reg;
    logic                  flat2_reg, blk2_reg;
    logic [DIVISOR_W-1:0]  rv2_reg, dv2_reg, rh2_reg, dh2_reg;

    // stage 2, hsv to rgb raw color
    logic [ONE_W-1:0]      raw2_next [3];
    logic [ONE_W-1:0]      raw2_reg  [3];

    // divider stages
    logic [DIVISOR_W-1:0]  rv_reg [DIV_STAGES];
    logic [DIVISOR_W-1:0]  dv_reg [DIV_STAGES];
    logic [DIVISOR_W-1:0]  rh_reg [DIV_STAGES];
    logic [DIVISOR_W-1:0]  dh_reg [DIV_STAGES];
    logic [FRAC_BITS-1:0]  qv_reg [DIV_STAGES];
    logic [FRAC_BITS-1:0]  qh_reg [DIV_STAGES];
    logic [ONE_W-1:0]      wd_reg [DIV_STAGES];
    logic                  flat_reg [DIV_STAGES];
    logic                  blk_reg  [DIV_STAGES];

    logic [DIVISOR_W-1:0]  rv_next [DIV_STAGES];
    logic [DIVISOR_W-1:0]  rh_next [DIV_STAGES];
    logic [FRAC_BITS-1:0]  qv_next [DIV_STAGES];
    logic [FRAC_BITS-1:0]  qh_next [DIV_STAGES];

    // hsv to rgb shading chain
    logic [2*ONE_W-1:0]    prod3_reg [3];
    logic [ONE_W-1:0]      raw3_reg  [3];
    logic [ONE_W:0]        lift4_reg [3];
    logic [2*ONE_W:0]      mul5_reg  [3];
    logic [ONE_W+11:0]     sc6_reg   [3];
    logic [24:0]           tn7_reg   [3];
    logic [7:0]            byte8_reg [3];
    logic [23:0]           rgb9_reg, rgb10_reg;

    // output
    out_item_t             result_next, result_reg;

    function automatic logic [DIVISOR_W:0] div_step(
        input logic [DIVISOR_W-1:0] rem,
        input logic [DIVISOR_W-1:0] dvs
    );
        logic [DIVISOR_W:0] dbl;
        logic [DIVISOR_W:0] diff;
        dbl  = {rem, 1'b0};
        diff = dbl - {1'b0, dvs};
        if (dbl >= {1'b0, dvs})
        begin
            return {1'b1, diff[DIVISOR_W-1:0]};
        end
        return {1'b0, dbl[DIVISOR_W-1:0]};
    endfunction

    assign busy = 1'b0;

    // ---------------- stage 1: max/min, sextant split ----------------
    always_comb
    begin
        logic [7:0] r, g, b;
        r = request.rgb_in[23:16];
        g = request.rgb_in[15:8];
        b = request.rgb_in[7:0];
        mx1_next = r;
        mn1_next = r;
        if (g > mx1_next)
        begin
            mx1_next = g;
        end
        if (b > mx1_next)
        begin
            mx1_next = b;
        end
        if (g < mn1_next)
        begin
            mn1_next = g;
        end
        if (b < mn1_next)
        begin
            mn1_next = b;
        end
        // ties go red, then green, then blue
        if (mx1_next == r)
        begin
            msel1_next = MAX_R;
        end
        else if (mx1_next == g)
        begin
            msel1_next = MAX_G;
        end
        else
        begin
            msel1_next = MAX_B;
        end
        t1_next = {3'b000, request.hue_in} * (FRAC_BITS + 3)'(6);
    end

    // ---------------- stage 2: hue numerator, brightness, raw color ------
    assign d2     = mx1_reg - mn1_reg;
    assign d6_2   = {3'b000, d2} * DIVISOR_W'(6);
    assign n_red2 = {3'b000, item_reg[1].rgb_in[15:8]} + d6_2
                  - {3'b000, item_reg[1].rgb_in[7:0]};

    always_comb
    begin
        logic [DIVISOR_W-1:0] r, g, b;
        r = {3'b000, item_reg[1].rgb_in[23:16]};
        g = {3'b000, item_reg[1].rgb_in[15:8]};
        b = {3'b000, item_reg[1].rgb_in[7:0]};
        case (msel1_reg)
            MAX_R:   n2_next = (n_red2 >= d6_2) ? n_red2 - d6_2 : n_red2;
            MAX_G:   n2_next = b + {d2, 1'b0} - r;
            MAX_B:   n2_next = r + {1'b0, d2, 2'b00} - g;
            default: n2_next = '0;
        endcase
        // (mx << 16) / 255 == 257*mx + (mx == 255)
        w2_next = {1'b0, mx1_reg, mx1_reg} + ONE_W'(mx1_reg == 8'hFF);
    end

    always_comb
    begin
        logic [ONE_W-1:0] i, j;
        i = {1'b0, frac1_reg};
        j = ONE - i;
        case (sext1_reg)
            3'd0:
            begin
                raw2_next[0] = ONE; raw2_next[1] = i;   raw2_next[2] = '0;
            end
            3'd1:
            begin
                raw2_next[0] = j;   raw2_next[1] = ONE; raw2_next[2] = '0;
            end
            3'd2:
            begin
                raw2_next[0] = '0;  raw2_next[1] = ONE; raw2_next[2] = i;
            end
            3'd3:
            begin
                raw2_next[0] = '0;  raw2_next[1] = j;   raw2_next[2] = ONE;
            end
            3'd4:
            begin
                raw2_next[0] = i;   raw2_next[1] = '0;  raw2_next[2] = ONE;
            end
            default:
            begin
                raw2_next[0] = ONE; raw2_next[1] = '0;  raw2_next[2] = j;
            end
        endcase
    end

    // ---------------- divider stages: two bits each ----------------
    always_comb
    begin
        logic [DIVISOR_W-1:0] rv_in, dv_in, rh_in, dh_in, rv_mid, rh_mid;
        logic [FRAC_BITS-1:0] qv_in, qh_in;
        logic                 bv0, bv1, bh0, bh1;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rv_in = rv2_reg; dv_in = dv2_reg; rh_in = rh2_reg; dh_in = dh2_reg;
                qv_in = '0;      qh_in = '0;
            end
            else
            begin
                rv_in = rv_reg[k-1]; dv_in = dv_reg[k-1];
                rh_in = rh_reg[k-1]; dh_in = dh_reg[k-1];
                qv_in = qv_reg[k-1]; qh_in = qh_reg[k-1];
            end
            {bv0, rv_mid}     = div_step(rv_in, dv_in);
            {bv1, rv_next[k]} = div_step(rv_mid, dv_in);
            {bh0, rh_mid}     = div_step(rh_in, dh_in);
            {bh1, rh_next[k]} = div_step(rh_mid, dh_in);
            qv_next[k] = {qv_in[FRAC_BITS-3:0], bv0, bv1};
            qh_next[k] = {qh_in[FRAC_BITS-3:0], bh0, bh1};
        end
    end

    // ---------------- output assembly ----------------
    always_comb
    begin
        logic [ONE_W-1:0] v;
        logic [15:0]      h;
        if (flat_reg[DIV_STAGES-1])
        begin
            v = blk_reg[DIV_STAGES-1] ? '0 : ONE;
            h = '0;
        end
        else
        begin
            v = {1'b0, qv_reg[DIV_STAGES-1]};
            h = qh_reg[DIV_STAGES-1];
        end
        if (item_reg[DEPTH-1].mode)
        begin
            result_next.rgb_out        = rgb10_reg;
            result_next.hue_out        = item_reg[DEPTH-1].hue_in;
            result_next.whiteness_out  = item_reg[DEPTH-1].whiteness_in;
            result_next.brightness_out = item_reg[DEPTH-1].brightness_in;
        end
        else
        begin
            result_next.rgb_out        = item_reg[DEPTH-1].rgb_in;
            result_next.hue_out        = h;
            result_next.whiteness_out  = v;
            result_next.brightness_out = wd_reg[DIV_STAGES-1];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEPTH-1:1], start};
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg[1] <= request;
        for (int s = 2; s <= DEPTH; s++)
        begin
            item_reg[s] <= item_reg[s-1];
        end

        // stage 1
        mx1_reg   <= mx1_next;
        mn1_reg   <= mn1_next;
        msel1_reg <= msel1_next;
        sext1_reg <= t1_next[FRAC_BITS+2:FRAC_BITS];
        frac1_reg <= t1_next[FRAC_BITS-1:0];

        // stage 2
        w2_reg    <= w2_next;
        flat2_reg <= (mx1_reg == mn1_reg);
        blk2_reg  <= (mx1_reg == 8'h00);
        rv2_reg   <= {3'b000, mn1_reg};
        dv2_reg   <= {3'b000, mx1_reg};
        rh2_reg   <= n2_next;
        dh2_reg   <= d6_2;

        // divider
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rv_reg[k] <= rv_next[k];
            rh_reg[k] <= rh_next[k];
            qv_reg[k] <= qv_next[k];
            qh_reg[k] <= qh_next[k];
            if (k == 0)
            begin
                dv_reg[k]   <= dv2_reg;
                dh_reg[k]   <= dh2_reg;
                wd_reg[k]   <= w2_reg;
                flat_reg[k] <= flat2_reg;
                blk_reg[k]  <= blk2_reg;
            end
            else
            begin
                dv_reg[k]   <= dv_reg[k-1];
                dh_reg[k]   <= dh_reg[k-1];
                wd_reg[k]   <= wd_reg[k-1];
                flat_reg[k] <= flat_reg[k-1];
                blk_reg[k]  <= blk_reg[k-1];
            end
        end

        // shading: lift toward white, scale by brightness, make a byte
        for (int c = 0; c < 3; c++)
        begin
            raw2_reg[c]  <= raw2_next[c];
            prod3_reg[c] <= item_reg[2].whiteness_in * (ONE - raw2_reg[c]);
            raw3_reg[c]  <= raw2_reg[c];
            lift4_reg[c] <= {1'b0, raw3_reg[c]}
                          + prod3_reg[c][2*ONE_W-1:FRAC_BITS];
            mul5_reg[c]  <= lift4_reg[c] * item_reg[4].brightness_in;
            if (mul5_reg[c][2*ONE_W:FRAC_BITS] > {2'b00, ONE})
            begin
                sc6_reg[c] <= ONE * BYTE_SCALE;
            end
            else
            begin
                sc6_reg[c] <= mul5_reg[c][FRAC_BITS+ONE_W-1:FRAC_BITS] * BYTE_SCALE;
            end
            tn7_reg[c]   <= sc6_reg[c][ONE_W+11:FRAC_BITS] * TENTH_MUL;
            byte8_reg[c] <= tn7_reg[c][23:16];
        end
        rgb9_reg   <= {byte8_reg[0], byte8_reg[1], byte8_reg[2]};
        rgb10_reg  <= rgb9_reg;
        result_reg <= result_next;
    end

    assign done   = vld_reg[DEPTH];
    assign result = result_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##DEPTH done)
        else $error("item did not emerge after pipeline latency");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !item_reg[DEPTH].mode) |->
        (result.whiteness_out <= ONE && result.brightness_out <= ONE))
        else $error("whiteness or brightness above one");

    a_white: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DEPTH-1] && item_reg[DEPTH-1].mode
         && item_reg[DEPTH-1].whiteness_in == ONE
         && item_reg[DEPTH-1].brightness_in == ONE)
        |=> (result.rgb_out == 24'hFFFFFF))
        else $error("full whiteness and brightness not white");

endmodule

>>> sim/tb_rgb_hsv_color_conversion.sv
// ----------------------------------------------------------------------------
// tb_rgb_hsv_color_conversion: self-checking bench for the color converter
// Drives directed and random colors in both modes with random gaps, predicts
// every result in fixed point and checks each done strobe in order.
// ----------------------------------------------------------------------------
module tb_rgb_hsv_color_conversion;
    import rhcc_pkg::*;

    localparam bit MODE_TO_HSV = 1'b0;
    localparam bit MODE_TO_RGB = 1'b1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 1500;

    // ------------------------------------------------------------------------
    // Fixed-point predictor of the converter
    // ------------------------------------------------------------------------
    function automatic logic [7:0] chan_byte(longint unsigned x);
        if (x > ONE)
        begin
            x = ONE;
        end
        return 8'((x * 2559) / (longint'(ONE) * 10));
    endfunction

    function automatic logic [7:0] shade_chan(longint unsigned raw, longint unsigned wh,
                                              longint unsigned br);
        longint unsigned lifted;
        lifted = raw + ((wh * (ONE - raw)) >> FRAC_BITS);
        return chan_byte((lifted * br) >> FRAC_BITS);
    endfunction

    function automatic out_item_t convert_color(in_item_t it);
        out_item_t o;
        longint unsigned r, g, b, mx, mn, d, n, t, i, j, wh, br;
        longint unsigned cr, cg, cb;
        int sext;
        o = '0;
        if (it.mode == MODE_TO_HSV)
        begin
            r = it.rgb_in[23:16];
            g = it.rgb_in[15:8];
            b = it.rgb_in[7:0];
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            o.rgb_out = it.rgb_in;
            o.brightness_out = 17'((mx << FRAC_BITS) / 255);
            if (mx > 0)
            begin
                o.whiteness_out = 17'((mn << FRAC_BITS) / mx);
                if (mx > mn)
                begin
                    d = mx - mn;
                    // ties resolve red, then green, then blue
                    if (mx == r)
                    begin
                        n = g + 6 * d - b;
                        if (n >= 6 * d) n -= 6 * d;
                    end
                    else if (mx == g)
                        n = b + 2 * d - r;
                    else
                        n = r + 4 * d - g;
                    o.hue_out = 16'((n << FRAC_BITS) / (6 * d));
                end
            end
        end
        else
        begin
            wh = it.whiteness_in;
            br = it.brightness_in;
            t = longint'(it.hue_in) * 6;
            sext = int'(t >> FRAC_BITS);
            i = t & (ONE - 1);
            j = ONE - i;
            case (sext)
                0: begin cr = ONE; cg = i;   cb = 0;   end
                1: begin cr = j;   cg = ONE; cb = 0;   end
                2: begin cr = 0;   cg = ONE; cb = i;   end
                3: begin cr = 0;   cg = j;   cb = ONE; end
                4: begin cr = i;   cg = 0;   cb = ONE; end
                default: begin cr = ONE; cg = 0; cb = j; end
            endcase
            o.rgb_out = {shade_chan(cr, wh, br), shade_chan(cg, wh, br),
                         shade_chan(cb, wh, br)};
            o.hue_out = it.hue_in;
            o.whiteness_out = it.whiteness_in;
            o.brightness_out = it.brightness_in;
        end
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: holds predicted colors in issue order
    // ------------------------------------------------------------------------
    class color_scoreboard;
        out_item_t pending[$];
        int errors;

        function void note_item(in_item_t it);
            pending.push_back(convert_color(it));
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending.size() == 0)
            begin
                $error("result with no item outstanding: %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.rgb_out !== exp.rgb_out)
            begin
                $error("rgb_out exp %h got %h", exp.rgb_out, got.rgb_out);
                errors++;
            end
            if (got.hue_out !== exp.hue_out)
            begin
                $error("hue_out exp %h got %h", exp.hue_out, got.hue_out);
                errors++;
            end
            if (got.whiteness_out !== exp.whiteness_out)
            begin
                $error("whiteness_out exp %h got %h", exp.whiteness_out, got.whiteness_out);
                errors++;
            end
            if (got.brightness_out !== exp.brightness_out)
            begin
                $error("brightness_out exp %h got %h", exp.brightness_out,
                       got.brightness_out);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_item_t request;
    logic done;
    out_item_t result;
    color_scoreboard sb;
    int idle_cycles;

    rgb_hsv_color_conversion dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // results cannot be held off: sample every strobe at the edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    // watchdog: cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // present one item after a random gap and hold it until accepted
    task automatic issue_item(in_item_t it, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(it);
    endtask

    function automatic in_item_t make_item(bit m, logic [23:0] rgb, logic [15:0] h,
                                           logic [16:0] w, logic [16:0] b);
        in_item_t it;
        it.mode = m;
        it.rgb_in = rgb;
        it.hue_in = h;
        it.whiteness_in = w;
        it.brightness_in = b;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int sel;
        it = make_item(1'($urandom_range(0, 1)), 24'($urandom), 16'($urandom),
                       17'($urandom), 17'($urandom));
        sel = $urandom_range(0, 9);
        // bias toward ties, grays and in-range fractions
        if (sel == 0)
            it.rgb_in = {3{it.rgb_in[7:0]}};
        else if (sel == 1)
            it.rgb_in[15:8] = it.rgb_in[23:16];
        else if (sel == 2)
            it.rgb_in[7:0] = it.rgb_in[15:8];
        if (sel < 7)
        begin
            it.whiteness_in = 17'($urandom_range(0, ONE));
            it.brightness_in = 17'($urandom_range(0, ONE));
        end
        return it;
    endfunction

    initial
    begin
        bit burst;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: black, white, gray, pure and tied primaries
        issue_item(make_item(MODE_TO_HSV, 24'h000000, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_HSV, 24'hFFFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF), 0);
        issue_item(make_item(MODE_TO_HSV, 24'h808080, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_HSV, 24'hFF0000, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_HSV, 24'h00FF00, 0, 0, 0), 1);
        issue_item(make_item(MODE_TO_HSV, 24'h0000FF, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_HSV, 24'hFFFF00, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_HSV, 24'h00FFFF, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_HSV, 24'hFF00FF, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_HSV, 24'hFF0001, 0, 0, 0), 1);
        issue_item(make_item(MODE_TO_HSV, 24'h010000, 0, 0, 0), 0);
        // directed reverse: each sextant, full/zero/out-of-range fractions
        for (int s = 0; s < 6; s++)
            issue_item(make_item(MODE_TO_RGB, 0, 16'(s * 10923 + 100), 0, ONE), 0);
        issue_item(make_item(MODE_TO_RGB, 0, 16'hFFFF, ONE, ONE), 0);
        issue_item(make_item(MODE_TO_RGB, 0, 0, 0, 0), 0);
        issue_item(make_item(MODE_TO_RGB, 24'hFFFFFF, 16'h8000, 17'h1FFFF, 17'h1FFFF), 1);
        issue_item(make_item(MODE_TO_RGB, 0, 16'h2AAA, 17'h1FFFF, 17'h08000), 0);
        issue_item(make_item(MODE_TO_RGB, 0, 16'h5555, 17'h04000, 17'h1FFFF), 0);

        // random items; some bursts run back to back with no gaps
        burst = 0;
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if ((k % 100) == 0)
                burst = ($urandom_range(0, 2) == 0);
            issue_item(random_item(), !burst);
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DEPTH + 5) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
